// ===== design/osst_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// osst_pkg
// Shared types and constants for the ordered integer set table.
// ----------------------------------------------------------------------------
package osst_pkg;

    localparam int CMD_W        = 3;
    localparam int VALUE_W      = 32;
    localparam int STATUS_W     = 2;
    localparam int MEM_W        = VALUE_W + 1;   // {mark, value}
    localparam int CAPACITY_DEF = 64;

    typedef enum logic [CMD_W-1:0] {
        OP_INSERT = 3'd0,
        OP_REMOVE = 3'd1,
        OP_MARK   = 3'd2,
        OP_KEEP   = 3'd3,
        OP_QUERY  = 3'd4,
        OP_READ   = 3'd5,
        OP_CLEAR  = 3'd6
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2
    } t_status;

    // command handed to the engine on the accept edge
    typedef struct packed {
        logic               start;
        t_op                op;
        logic [VALUE_W-1:0] value;
    } t_cmd_req;

    // completion flags from the engine
    typedef struct packed {
        logic    done;
        logic    found;
        t_status status;
    } t_res_flags;

endpackage

// ===== design/ordered_integer_set_table.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ordered_integer_set_table
// Set of distinct 32-bit values in insertion order with insert, remove,
// mark / keep-marked, query, positional read and clear; one result per beat.
// ----------------------------------------------------------------------------
// One command is in flight at a time. Insert, remove, mark, query and keep
// walk the live entries through the table memory's single read port (one
// entry per cycle, registered read data) and then finish in S_FIN. An
// in-range read goes through S_RDATA to S_FIN; an out-of-range read, clear
// or an unused code goes straight to S_FIN. A result held back by the master
// side keeps the engine in S_FIN until the output register can take it.
// A finished result sits in the output register while the next command is
// accepted. Marks are stored beside each value in the same memory word, and
// only entries below the count are ever read, so no clearing pass runs after
// reset.
module ordered_integer_set_table #(
    parameter int CAPACITY = osst_pkg::CAPACITY_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    // cmd, value, position
    input  logic [((osst_pkg::CMD_W + osst_pkg::VALUE_W + $clog2(CAPACITY) + 7) / 8) * 8 - 1:0]
                 i_s_tdata,
    input  logic i_s_tvalid,
    output logic o_s_tready,
    // found, read_value, count, status
    output logic [((1 + osst_pkg::VALUE_W + $clog2(CAPACITY + 1) + osst_pkg::STATUS_W + 7) / 8)
                  * 8 - 1:0]
                 o_m_tdata,
    output logic o_m_tvalid,
    input  logic i_m_tready
);

    import osst_pkg::*;

    localparam int AW    = $clog2(CAPACITY);
    localparam int CW    = $clog2(CAPACITY + 1);
    localparam int OUT_W = ((1 + VALUE_W + CW + STATUS_W + 7) / 8) * 8;

    t_cmd_req           req;
    logic [AW-1:0]      in_pos;
    logic               eng_idle;
    t_res_flags         eng_res;
    logic [VALUE_W-1:0] eng_rd_value;
    logic [CW-1:0]      eng_count;
    logic               res_ready;
    logic               s_accept;

    logic               mem_we;
    logic [AW-1:0]      mem_waddr;
    logic [MEM_W-1:0]   mem_wdata;
    logic               mem_re;
    logic [AW-1:0]      mem_raddr;
    logic [MEM_W-1:0]   mem_rdata;

    logic               r_out_valid;
    logic               r_out_found;
    logic [VALUE_W-1:0] r_out_rd;
    logic [CW-1:0]      r_out_count;
    t_status            r_out_status;

    assign o_s_tready = eng_idle;
    assign s_accept   = i_s_tvalid && eng_idle;

    assign req.start = s_accept;
    assign req.op    = t_op'(i_s_tdata[CMD_W-1:0]);
    assign req.value = i_s_tdata[CMD_W +: VALUE_W];
    assign in_pos    = i_s_tdata[CMD_W + VALUE_W +: AW];

    // engine may only finish into a free (or draining) output slot
    assign res_ready = !r_out_valid || i_m_tready;

    osst_engine #(
        .CAPACITY (CAPACITY)
    ) u_engine (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (req),
        .i_pos        (in_pos),
        .i_res_ready  (res_ready),
        .o_idle       (eng_idle),
        .o_res        (eng_res),
        .o_read_value (eng_rd_value),
        .o_count      (eng_count),
        .o_mem_we     (mem_we),
        .o_mem_waddr  (mem_waddr),
        .o_mem_wdata  (mem_wdata),
        .o_mem_re     (mem_re),
        .o_mem_raddr  (mem_raddr),
        .i_mem_rdata  (mem_rdata)
    );

    osst_mem #(
        .DEPTH (CAPACITY),
        .WIDTH (MEM_W)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (eng_res.done) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
        if (eng_res.done) begin
            r_out_found  <= eng_res.found;
            r_out_rd     <= eng_rd_value;
            r_out_count  <= eng_count;
            r_out_status <= eng_res.status;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = OUT_W'({r_out_status, r_out_count, r_out_rd, r_out_found});

    // count never passes the capacity
    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_count <= CW'(CAPACITY)))
        else $error("count above capacity");

    // a refused insert only happens on a full table with the value absent
    a_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_status == ST_FULL)
            |-> (!r_out_found && r_out_count == CW'(CAPACITY)))
        else $error("full status with found or short table");

    // out-of-range read returns zero data
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_status == ST_RANGE) |-> (r_out_rd == '0 && !r_out_found))
        else $error("range status with data");

    // engine never overwrites a result still waiting
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        eng_res.done |-> (!r_out_valid || i_m_tready))
        else $error("result overrun");

    // after a command is taken the engine is busy
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_accept |=> !o_s_tready)
        else $error("accepted while busy");

endmodule

// ===== design/osst_mem.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// osst_mem
// Single-port-write, single-port-read table memory, registered read data.
// ----------------------------------------------------------------------------
module osst_mem #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 33
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/osst_engine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// osst_engine
// Command sequencer: walks the table memory once per insert, remove, mark,
// query or keep, compares, shifts down on remove, marks on mark, compacts on keep and appends on insert.
// ----------------------------------------------------------------------------
module osst_engine #(
    parameter int CAPACITY = osst_pkg::CAPACITY_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  osst_pkg::t_cmd_req                 i_req,
    input  logic [$clog2(CAPACITY)-1:0]        i_pos,
    input  logic                               i_res_ready,
    output logic                               o_idle,
    output osst_pkg::t_res_flags               o_res,
    output logic [osst_pkg::VALUE_W-1:0]       o_read_value,
    output logic [$clog2(CAPACITY+1)-1:0]      o_count,
    output logic                               o_mem_we,
    output logic [$clog2(CAPACITY)-1:0]        o_mem_waddr,
    output logic [osst_pkg::MEM_W-1:0]         o_mem_wdata,
    output logic                               o_mem_re,
    output logic [$clog2(CAPACITY)-1:0]        o_mem_raddr,
    input  logic [osst_pkg::MEM_W-1:0]         i_mem_rdata
);

    import osst_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [CW-1:0] CAP_CNT = CW'(CAPACITY);

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_RDATA,
        S_FIN
    } t_state;

    t_state             r_state, n_state;
    t_op                r_op, n_op;
    logic [VALUE_W-1:0] r_value, n_value;
    logic [CW-1:0]      r_count, n_count;
    logic [CW-1:0]      r_ra, n_ra;       // next read address
    logic               r_dv, n_dv;       // read data valid this cycle
    logic [AW-1:0]      r_di, n_di;       // index of read data
    logic [CW-1:0]      r_w, n_w;         // compaction write pointer
    logic               r_found, n_found;
    t_status            r_status, n_status;
    logic [VALUE_W-1:0] r_rd_value, n_rd_value;

    logic               done;
    logic [VALUE_W-1:0] d_val;
    logic               d_mark;
    logic               match;

    assign d_val  = i_mem_rdata[VALUE_W-1:0];
    assign d_mark = i_mem_rdata[VALUE_W];
    assign match  = (d_val == r_value);

    // Writes always land below the address being read (shift down, compact,
    // mark in place), so the read-ahead never sees a stale entry.
    always_comb begin
        n_state    = r_state;
        n_op       = r_op;
        n_value    = r_value;
        n_count    = r_count;
        n_ra       = r_ra;
        n_dv       = 1'b0;
        n_di       = r_di;
        n_w        = r_w;
        n_found    = r_found;
        n_status   = r_status;
        n_rd_value = r_rd_value;
        done        = 1'b0;
        o_mem_we    = 1'b0;
        o_mem_waddr = '0;
        o_mem_wdata = '0;
        o_mem_re    = 1'b0;
        o_mem_raddr = '0;

        case (r_state)
            S_IDLE: begin
                if (i_req.start) begin
                    n_op       = i_req.op;
                    n_value    = i_req.value;
                    n_found    = 1'b0;
                    n_status   = ST_OK;
                    n_rd_value = '0;
                    n_ra       = '0;
                    n_w        = '0;
                    case (i_req.op)
                        OP_INSERT, OP_REMOVE, OP_MARK, OP_QUERY, OP_KEEP: begin
                            n_state = S_WALK;
                        end
                        OP_READ: begin
                            if (CW'(i_pos) < r_count) begin
                                o_mem_re    = 1'b1;
                                o_mem_raddr = i_pos;
                                n_state     = S_RDATA;
                            end else begin
                                n_status = ST_RANGE;
                                n_state  = S_FIN;
                            end
                        end
                        OP_CLEAR: begin
                            n_count = '0;
                            n_state = S_FIN;
                        end
                        default: begin
                            n_state = S_FIN;
                        end
                    endcase
                end
            end

            S_RDATA: begin
                n_rd_value = d_val;
                n_state    = S_FIN;
            end

            S_WALK: begin
                if (r_ra < r_count) begin
                    o_mem_re    = 1'b1;
                    o_mem_raddr = r_ra[AW-1:0];
                    n_ra        = r_ra + CW'(1);
                    n_dv        = 1'b1;
                    n_di        = r_ra[AW-1:0];
                end
                if (r_dv) begin
                    case (r_op)
                        OP_REMOVE: begin
                            if (match) begin
                                n_found = 1'b1;
                            end else if (r_found) begin
                                o_mem_we    = 1'b1;
                                o_mem_waddr = r_di - AW'(1);
                                o_mem_wdata = i_mem_rdata;
                            end
                        end
                        OP_KEEP: begin
                            if (d_mark) begin
                                o_mem_we    = 1'b1;
                                o_mem_waddr = r_w[AW-1:0];
                                o_mem_wdata = {1'b0, d_val};
                                n_w         = r_w + CW'(1);
                            end
                        end
                        OP_MARK: begin
                            if (match) begin
                                n_found     = 1'b1;
                                o_mem_we    = 1'b1;
                                o_mem_waddr = r_di;
                                o_mem_wdata = {1'b1, d_val};
                            end
                        end
                        default: begin
                            if (match) begin
                                n_found = 1'b1;
                            end
                        end
                    endcase
                end else if (r_ra >= r_count) begin
                    // walk drained: settle the count
                    n_state = S_FIN;
                    case (r_op)
                        OP_INSERT: begin
                            if (!r_found) begin
                                if (r_count >= CAP_CNT) begin
                                    n_status = ST_FULL;
                                end else begin
                                    o_mem_we    = 1'b1;
                                    o_mem_waddr = r_count[AW-1:0];
                                    o_mem_wdata = {1'b0, r_value};
                                    n_count     = r_count + CW'(1);
                                end
                            end
                        end
                        OP_REMOVE: begin
                            if (r_found) begin
                                n_count = r_count - CW'(1);
                            end
                        end
                        OP_KEEP: begin
                            n_count = r_w;
                        end
                        default: begin
                        end
                    endcase
                end
            end

            S_FIN: begin
                if (i_res_ready) begin
                    done    = 1'b1;
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_dv    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_dv    <= n_dv;
        end
        r_op       <= n_op;
        r_value    <= n_value;
        r_ra       <= n_ra;
        r_di       <= n_di;
        r_w        <= n_w;
        r_found    <= n_found;
        r_status   <= n_status;
        r_rd_value <= n_rd_value;
    end

    assign o_idle       = (r_state == S_IDLE);
    assign o_res        = '{done: done, found: r_found, status: r_status};
    assign o_read_value = r_rd_value;
    assign o_count      = r_count;

endmodule
